// File: sv/slcp_pkg.sv
// shared types and constants of the serial led command line parser
package slcp_pkg;

   localparam int unsigned LINE_LEN_DEFAULT   = 64;
   localparam int unsigned MAX_TOKENS_DEFAULT = 5;
   localparam logic [15:0] TIMEOUT_RESET      = 16'd10000;
   localparam logic [15:0] HOLD_RESET         = 16'd5000;

   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_HASH  = 8'd35;
   localparam logic [7:0] CHAR_SLASH = 8'd47;
   localparam logic [7:0] CHAR_TOP   = 8'd126;

   typedef enum logic [2:0] {
      MSG_NONE     = 3'd0,
      MSG_PROMPT   = 3'd1,
      MSG_OK       = 3'd2,
      MSG_TOO_LONG = 3'd3,
      MSG_TIMEOUT  = 3'd4,
      MSG_ARGS     = 3'd5,
      MSG_INVALID  = 3'd6
   } msg_type;

   typedef enum logic [1:0] {
      LED_NONE   = 2'd0,
      LED_ON     = 2'd1,
      LED_OFF    = 2'd2,
      LED_TOGGLE = 2'd3
   } led_type;

   typedef enum logic [0:0] {
      REG_TIMEOUT = 1'b0,
      REG_HOLD    = 1'b1
   } reg_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_RECV = 2'd1,
      MODE_HOLD = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_READY,
      ST_SCAN_START,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take;       // handle the accepted beat
      logic scan_start; // start reading the store
      logic scan_step;  // consume one read byte
      logic scan_done;  // produce the end of line result
      logic deliver;    // result taken
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic need_scan;  // accepted beat ends a line
      logic scan_last;  // final byte is being read
   } sts_type;

   function automatic logic [7:0] fold(input logic [7:0] c);
      fold = (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
   endfunction

endpackage

// File: sv/slcp_if.sv
// valid/ready channel interfaces of the parser
interface slcp_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] rx_byte;
   modport source (output valid, action, rx_byte, input ready);
   modport sink (input valid, action, rx_byte, output ready);
endinterface

interface slcp_rsp_if;
   logic       valid;
   logic       ready;
   logic       echo_valid;
   logic [7:0] echo_byte;
   logic [2:0] message_code;
   logic [1:0] led_op;
   modport source (output valid, echo_valid, echo_byte, message_code, led_op,
                   input ready);
   modport sink (input valid, echo_valid, echo_byte, message_code, led_op,
                 output ready);
endinterface

interface slcp_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: sv/serial_led_command_line_parser_core.sv
// top level of the serial led command line parser
// Each request beat is a received byte or one time tick and yields exactly one
// response beat with echo, message code and led command. An ordinary beat is
// accepted, then the registered result is offered. A byte that ends a stored
// line runs a token scan that reads the line store one byte per cycle; at most
// LINE_LEN - 1 bytes are stored when a line ends. The scan rate is set by the
// single read port of the line store. Configuration writes are taken in any
// cycle.
module serial_led_command_line_parser_core #(
   parameter int unsigned LINE_LEN   = slcp_pkg::LINE_LEN_DEFAULT,
   parameter int unsigned MAX_TOKENS = slcp_pkg::MAX_TOKENS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   slcp_req_if.sink  req,
   slcp_rsp_if.source rsp,
   slcp_csr_if.sink  csr
);
   import slcp_pkg::*;

   ctl_type ctl;
   sts_type sts;

   // register writes are always taken
   assign csr.ready = 1'b1;

   slcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   // datapath holds the result registers, stable while the beat waits
   slcp_dp #(
      .LINE_LEN   (LINE_LEN),
      .MAX_TOKENS (MAX_TOKENS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_action   (req.action),
      .req_rx_byte  (req.rx_byte),
      .csr_we       (csr.valid),
      .csr_index    (csr.index),
      .csr_data     (csr.data),
      .ctl          (ctl),
      .sts          (sts),
      .echo_valid   (rsp.echo_valid),
      .echo_byte    (rsp.echo_byte),
      .message_code (rsp.message_code),
      .led_op       (rsp.led_op)
   );
endmodule

// File: sv/slcp_ctrl.sv
// controller state machine of the parser
module slcp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  slcp_pkg::sts_type sts,
   output slcp_pkg::ctl_type ctl
);
   import slcp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_READY;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_READY: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.take = 1'b1;
               state_in = sts.need_scan ? ST_SCAN_START : ST_OUT;
            end
         end
         ST_SCAN_START: begin
            ctl.scan_start = 1'b1;
            state_in = sts.scan_last ? ST_SCAN_LAST : ST_SCAN;
         end
         ST_SCAN: begin
            ctl.scan_step = 1'b1;
            if (sts.scan_last) state_in = ST_SCAN_LAST;
         end
         ST_SCAN_LAST: begin
            ctl.scan_step = 1'b1;
            ctl.scan_done = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               ctl.deliver = 1'b1;
               state_in = ST_READY;
            end
         end
         default: state_in = ST_READY;
      endcase
   end
endmodule

// File: sv/slcp_dp.sv
// datapath of the parser: mode, counters, line store and token scan
module slcp_dp #(
   parameter int unsigned LINE_LEN   = slcp_pkg::LINE_LEN_DEFAULT,
   parameter int unsigned MAX_TOKENS = slcp_pkg::MAX_TOKENS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_action,
   input  logic [7:0]        req_rx_byte,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [15:0]       csr_data,
   input  slcp_pkg::ctl_type ctl,
   output slcp_pkg::sts_type sts,
   output logic              echo_valid,
   output logic [7:0]        echo_byte,
   output logic [2:0]        message_code,
   output logic [1:0]        led_op
);
   import slcp_pkg::*;

   localparam int AW = $clog2(LINE_LEN);
   localparam int PW = AW + 1;
   localparam int CW = $clog2(MAX_TOKENS + 1);

   logic [15:0] tmo_ff, hold_ff;
   mode_type    mode_ff;
   logic        prompt_ff, comment_ff;
   logic [PW-1:0] wpos_ff;
   logic [15:0] tick_ff;
   logic [7:0]  mem [LINE_LEN];
   logic [7:0]  rd_ff;
   logic [AW-1:0] raddr_ff;
   logic        inside_ff;
   logic [CW-1:0] count_ff;
   logic [2:0]  t0len_ff, t1len_ff;
   logic        t0ok_ff, on_ff, off_ff, tog_ff;
   logic        ov_ff;
   logic [7:0]  ob_ff;
   logic [2:0]  om_ff;
   logic [1:0]  ol_ff;

   wire [15:0] tlim = (tmo_ff == 16'd0) ? 16'd1 : tmo_ff;
   wire [15:0] hlim = (hold_ff == 16'd0) ? 16'd1 : hold_ff;
   wire [15:0] tick_inc = (tick_ff == 16'hFFFF) ? tick_ff : tick_ff + 16'd1;
   wire [7:0] c = req_rx_byte;
   wire is_eol = (c == CHAR_LF) || (c == CHAR_CR);

   assign sts.need_scan = (mode_ff == MODE_RECV) && !req_action && is_eol;
   assign sts.scan_last = ({1'b0, raddr_ff} + 1'b1) >= wpos_ff;

   assign echo_valid   = ov_ff;
   assign echo_byte    = ob_ff;
   assign message_code = om_ff;
   assign led_op       = ol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tmo_ff <= TIMEOUT_RESET;
         hold_ff <= HOLD_RESET;
      end else if (csr_we) begin
         if (csr_index == REG_TIMEOUT) tmo_ff <= csr_data;
         else hold_ff <= csr_data;
      end
   end

   // store write and registered read
   always_ff @(posedge clock) begin
      if (ctl.take && !req_action && c != 8'd0) begin
         if (mode_ff == MODE_IDLE) mem[AW'(0)] <= c;
         else if (mode_ff == MODE_RECV && !is_eol && wpos_ff < PW'(LINE_LEN))
            mem[wpos_ff[AW-1:0]] <= c;
      end
      rd_ff <= mem[ctl.scan_start ? AW'(0) : raddr_ff];
   end

   // token match for byte rd_ff at position within its token
   logic [7:0] fc;
   logic [2:0] pos;
   logic       starts;
   always_comb begin
      fc = fold(rd_ff);
      starts = !inside_ff;
      pos = starts ? 3'd0 : ((count_ff == CW'(1)) ? t0len_ff : t1len_ff);
   end

   // scan: one stored byte per cycle
   logic [CW-1:0] cnt_n;
   logic [2:0] l0_n, l1_n;
   logic t0_n, on_n, off_n, tg_n, in_n;
   always_comb begin
      cnt_n = count_ff; l0_n = t0len_ff; l1_n = t1len_ff;
      t0_n = t0ok_ff; on_n = on_ff; off_n = off_ff; tg_n = tog_ff;
      in_n = inside_ff;
      if (rd_ff == CHAR_SPACE) begin
         in_n = 1'b0;
      end else begin
         in_n = 1'b1;
         if (starts && count_ff < CW'(MAX_TOKENS)) cnt_n = count_ff + 1'b1;
         if (cnt_n == CW'(1)) begin
            if (l0_n != 3'd7) l0_n = l0_n + 3'd1;
            case (pos)
               3'd0: t0_n = (fc == 8'd108);
               3'd1: t0_n = t0_n && (fc == 8'd101);
               3'd2: t0_n = t0_n && (fc == 8'd100);
               default: t0_n = 1'b0;
            endcase
         end else if (cnt_n == CW'(2) && (starts || count_ff == CW'(2))) begin
            if (l1_n != 3'd7) l1_n = l1_n + 3'd1;
            case (pos)
               3'd0: begin on_n = fc == 8'd111; off_n = fc == 8'd111;
                  tg_n = fc == 8'd116; end
               3'd1: begin on_n = on_n && fc == 8'd110; off_n = off_n && fc == 8'd102;
                  tg_n = tg_n && fc == 8'd111; end
               3'd2: begin on_n = 1'b0; off_n = off_n && fc == 8'd102;
                  tg_n = tg_n && fc == 8'd103; end
               3'd3: begin on_n = 1'b0; off_n = 1'b0; tg_n = tg_n && fc == 8'd103; end
               3'd4: begin on_n = 1'b0; off_n = 1'b0; tg_n = tg_n && fc == 8'd108; end
               3'd5: begin on_n = 1'b0; off_n = 1'b0; tg_n = tg_n && fc == 8'd101; end
               default: begin on_n = 1'b0; off_n = 1'b0; tg_n = 1'b0; end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         prompt_ff <= 1'b1;
         comment_ff <= 1'b0;
         wpos_ff <= '0;
         tick_ff <= '0;
      end else begin
         if (ctl.take) begin
            ov_ff <= 1'b0;
            ob_ff <= 8'd0;
            om_ff <= MSG_NONE;
            ol_ff <= LED_NONE;
            if (mode_ff == MODE_IDLE && prompt_ff) begin
               om_ff <= MSG_PROMPT;
               prompt_ff <= 1'b0;
            end
            unique case (mode_ff)
               MODE_IDLE: begin
                  if (!req_action && c != 8'd0 &&
                      (is_eol || (c > 8'd31 && c < CHAR_TOP))) begin
                     if (comment_ff || c == CHAR_HASH || c == CHAR_SLASH) begin
                        ov_ff <= 1'b1;
                        ob_ff <= c;
                        comment_ff <= !is_eol;
                        if (is_eol) prompt_ff <= 1'b1;
                     end else if (!is_eol) begin
                        ov_ff <= 1'b1;
                        ob_ff <= c;
                        wpos_ff <= PW'(1);
                        tick_ff <= '0;
                        mode_ff <= MODE_RECV;
                     end
                  end
               end
               MODE_RECV: begin
                  if (req_action) begin
                     tick_ff <= tick_inc;
                     if (tick_inc >= tlim) begin
                        om_ff <= MSG_TIMEOUT;
                        mode_ff <= MODE_HOLD;
                        tick_ff <= '0;
                     end
                  end else if (c != 8'd0) begin
                     ov_ff <= 1'b1;
                     ob_ff <= c;
                     if (is_eol) begin
                        mode_ff <= MODE_HOLD;
                        tick_ff <= '0;
                     end else if (wpos_ff + 1'b1 >= PW'(LINE_LEN)) begin
                        wpos_ff <= PW'(LINE_LEN);
                        om_ff <= MSG_TOO_LONG;
                        mode_ff <= MODE_HOLD;
                        tick_ff <= '0;
                     end else begin
                        wpos_ff <= wpos_ff + 1'b1;
                     end
                  end
               end
               default: begin
                  if (req_action) begin
                     tick_ff <= tick_inc;
                     if (tick_inc >= hlim) begin
                        mode_ff <= MODE_IDLE;
                        prompt_ff <= 1'b1;
                        tick_ff <= '0;
                     end
                  end
               end
            endcase
         end
         // end of line result, with the final byte folded in
         if (ctl.scan_done) begin
            if (cnt_n == '0 || cnt_n >= CW'(MAX_TOKENS)) om_ff <= MSG_ARGS;
            else if (cnt_n < CW'(2) || !(t0_n && l0_n == 3'd3)) om_ff <= MSG_INVALID;
            else if (on_n && l1_n == 3'd2) begin om_ff <= MSG_OK; ol_ff <= LED_ON; end
            else if (off_n && l1_n == 3'd3) begin om_ff <= MSG_OK; ol_ff <= LED_OFF; end
            else if (tg_n && l1_n == 3'd6) begin om_ff <= MSG_OK; ol_ff <= LED_TOGGLE; end
            else om_ff <= MSG_INVALID;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.scan_start) begin
         raddr_ff <= AW'(1);
         inside_ff <= 1'b0;
         count_ff <= '0;
         t0len_ff <= '0; t1len_ff <= '0;
         t0ok_ff <= 1'b0; on_ff <= 1'b0; off_ff <= 1'b0; tog_ff <= 1'b0;
      end else if (ctl.scan_step) begin
         raddr_ff <= raddr_ff + 1'b1;
         inside_ff <= in_n;
         count_ff <= cnt_n;
         t0len_ff <= l0_n; t1len_ff <= l1_n;
         t0ok_ff <= t0_n; on_ff <= on_n; off_ff <= off_n; tog_ff <= tg_n;
      end else if (ctl.take) begin
         // first byte of the line is the one read at scan start
         raddr_ff <= '0;
      end
   end
endmodule

// File: tb/tb_slcp_if.sv
`timescale 1ns / 100ps
// interfaces are taken from the rtl; this file holds the testbench beat and reply records
package tb_slcp_pkg;
   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
   } rx_beat_type;

   typedef struct packed {
      logic       echo_valid;
      logic [7:0] echo_byte;
      logic [2:0] message_code;
      logic [1:0] led_op;
   } reply_type;
endpackage

// File: tb/tb_serial_led_command_line_parser_core.sv
`timescale 1ns / 100ps
// testbench of the serial led command line parser with a built-in predictor
module tb_serial_led_command_line_parser_core;
   import slcp_pkg::*;
   import tb_slcp_pkg::*;

   localparam int LINE_LEN   = 64;
   localparam int MAX_TOKENS = 5;
   localparam longint CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   slcp_req_if req ();
   slcp_rsp_if rsp ();
   slcp_csr_if csr ();

   serial_led_command_line_parser_core uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [15:0] timeout_reg, hold_reg;
   mode_type    p_mode;
   logic        p_prompt, p_comment;
   logic [7:0]  p_line [LINE_LEN];
   int          p_wpos;
   logic [15:0] p_ticks;

   rx_beat_type pending_beats[$];
   reply_type   expected_replies[$];
   int       mismatches = 0;
   longint   cycles = 0;
   bit       calm = 0;       // long stretch with no idling

   function automatic logic [7:0] lower(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic bit word_match(int st, int ln, string w);
      if (ln != w.len()) return 0;
      for (int i = 0; i < ln; i++)
         if (st + i >= LINE_LEN || lower(p_line[st + i]) != w[i]) return 0;
      return 1;
   endfunction

   // token scan of the stored line at end of line
   function automatic msg_type scan_line(output led_type led);
      int cnt, st[2], ln[2];
      bit in_tok;
      cnt = 0; st = '{0, 0}; ln = '{0, 0}; in_tok = 0;
      led = LED_NONE;
      for (int i = 0; i < p_wpos && i < LINE_LEN; i++) begin
         if (p_line[i] == CHAR_SPACE) in_tok = 0;
         else begin
            if (!in_tok) begin
               if (cnt < MAX_TOKENS) cnt++;
               if (cnt <= 2) st[cnt - 1] = i;
               in_tok = 1;
            end
            if (cnt <= 2) ln[cnt - 1]++;
         end
      end
      if (cnt == 0 || cnt >= MAX_TOKENS) return MSG_ARGS;
      if (cnt < 2 || !word_match(st[0], ln[0], "led")) return MSG_INVALID;
      if (word_match(st[1], ln[1], "on")) led = LED_ON;
      else if (word_match(st[1], ln[1], "off")) led = LED_OFF;
      else if (word_match(st[1], ln[1], "toggle")) led = LED_TOGGLE;
      else return MSG_INVALID;
      return MSG_OK;
   endfunction

   function automatic reply_type predict_reply(rx_beat_type b);
      reply_type r;
      logic [7:0] c;
      logic [15:0] tlim, hlim;
      led_type led;
      bit eol;
      r = '0;
      c = b.rx_byte;
      eol = (c == CHAR_LF || c == CHAR_CR);
      tlim = timeout_reg == 0 ? 16'd1 : timeout_reg;
      hlim = hold_reg == 0 ? 16'd1 : hold_reg;
      if (p_mode == MODE_IDLE && p_prompt) begin
         r.message_code = MSG_PROMPT;
         p_prompt = 0;
      end
      case (p_mode)
         MODE_IDLE: begin
            if (!b.action && c != 0 && (eol || (c > 31 && c < CHAR_TOP))) begin
               if (c == CHAR_HASH || c == CHAR_SLASH) p_comment = 1;
               if (p_comment) begin
                  r.echo_valid = 1; r.echo_byte = c;
                  if (eol) begin
                     p_comment = 0;
                     p_prompt = 1;
                  end
               end else if (!eol) begin
                  r.echo_valid = 1; r.echo_byte = c;
                  foreach (p_line[i]) p_line[i] = '0;
                  p_line[0] = c;
                  p_wpos = 1;
                  p_ticks = 0;
                  p_mode = MODE_RECV;
               end
            end
         end
         MODE_RECV: begin
            if (b.action) begin
               if (p_ticks != 16'hFFFF) p_ticks++;
               if (p_ticks >= tlim) begin
                  r.message_code = MSG_TIMEOUT;
                  p_mode = MODE_HOLD;
                  p_ticks = 0;
               end
            end else if (c != 0) begin
               r.echo_valid = 1; r.echo_byte = c;
               if (eol) begin
                  r.message_code = scan_line(led);
                  r.led_op = led;
                  p_mode = MODE_HOLD;
                  p_ticks = 0;
               end else begin
                  if (p_wpos < LINE_LEN) p_line[p_wpos] = c;
                  p_wpos++;
                  if (p_wpos >= LINE_LEN) begin
                     p_wpos = LINE_LEN;
                     r.message_code = MSG_TOO_LONG;
                     p_mode = MODE_HOLD;
                     p_ticks = 0;
                  end
               end
            end
         end
         default: begin
            if (b.action) begin
               if (p_ticks != 16'hFFFF) p_ticks++;
               if (p_ticks >= hlim) begin
                  p_mode = MODE_IDLE;
                  p_prompt = 1;
                  p_ticks = 0;
               end
            end
         end
      endcase
      return r;
   endfunction

   // stimulus helpers: queue beats only, prediction happens at acceptance
   task automatic push_byte(logic [7:0] c);
      pending_beats.push_back('{action: 1'b0, rx_byte: c});
   endtask

   task automatic push_tick(logic [7:0] junk = 8'h00);
      pending_beats.push_back('{action: 1'b1, rx_byte: junk});
   endtask

   task automatic push_text(string s);
      foreach (s[i]) push_byte(s[i]);
   endtask

   task automatic push_ticks(int n);
      repeat (n) push_tick(8'($urandom_range(0, 255)));
   endtask

   // random case mix of a command word
   function automatic string mix_case(string s);
      string o;
      o = s;
      foreach (o[i])
         if ($urandom_range(0, 1)) o[i] = (o[i] >= "a" && o[i] <= "z") ? o[i] - 8'd32 : o[i];
      return o;
   endfunction

   task automatic wait_drained();
      while (pending_beats.size() != 0 || expected_replies.size() != 0) @(posedge clock);
      repeat (LINE_LEN + 10) @(posedge clock);
   endtask

   task automatic write_reg(reg_type idx, logic [15:0] val);
      @(posedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= val;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      if (idx == REG_TIMEOUT) timeout_reg = val;
      else hold_reg = val;
   endtask

   // one random line, a led command in 45 of 100 cases
   task automatic push_random_line();
      int k;
      string w2;
      k = $urandom_range(0, 99);
      if (k < 45) begin
         case ($urandom_range(0, 3))
            0: w2 = "on";
            1: w2 = "off";
            2: w2 = "toggle";
            default: w2 = "of";
         endcase
         repeat ($urandom_range(0, 2)) push_byte(CHAR_SPACE);
         push_text(mix_case("led"));
         repeat ($urandom_range(1, 3)) push_byte(CHAR_SPACE);
         push_text(mix_case(w2));
         repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 1)) push_byte(CHAR_SPACE);
            else push_text(" x");
         end
         if ($urandom_range(0, 4) == 0) push_tick();
         if ($urandom_range(0, 5) == 0) push_byte(8'h00);
         push_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
      end else if (k < 60) begin
         push_byte($urandom_range(0, 1) ? CHAR_HASH : CHAR_SLASH);
         repeat ($urandom_range(0, 6)) push_byte(8'($urandom_range(0, 255)));
         push_byte(CHAR_LF);
      end else if (k < 75) begin
         repeat ($urandom_range(1, 10)) push_byte(8'($urandom_range(32, 125)));
         push_byte(CHAR_CR);
      end else if (k < 82) begin
         repeat ($urandom_range(LINE_LEN - 3, LINE_LEN + 2))
            push_byte(8'($urandom_range(32, 125)));
      end else begin
         repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 1)) push_tick(8'($urandom_range(0, 255)));
            else push_byte(8'($urandom_range(0, 255)));
         end
      end
      // ticks to leave hold, sometimes to time out
      push_ticks($urandom_range(0, 1) ? int'(hold_reg) + int'($urandom_range(0, 2))
                                      : int'($urandom_range(0, 5)));
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.action <= 1'b0;
         req.rx_byte <= 8'h00;
      end else begin
         if (req.valid && req.ready) begin
            expected_replies.push_back(predict_reply('{action: req.action,
                                                       rx_byte: req.rx_byte}));
            void'(pending_beats.pop_front());
         end
         if ((pending_beats.size() > 0) && (calm || $urandom_range(0, 99) >= 25)) begin
            req.valid   <= 1'b1;
            req.action  <= pending_beats[0].action;
            req.rx_byte <= pending_beats[0].rx_byte;
         end else if (!(req.valid && !req.ready)) begin
            req.valid <= 1'b0;
         end
      end
   end

   // reply monitor and ready generator
   always @(posedge clock) begin
      reply_type got, exp_r;
      if (reset) rsp.ready <= 1'b0;
      else begin
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.echo_valid, rsp.echo_byte, rsp.message_code, rsp.led_op};
            if (expected_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected reply beat %p", got);
            end else begin
               exp_r = expected_replies.pop_front();
               if (got !== exp_r) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("reply mismatch: expected %p got %p", exp_r, got);
               end
            end
         end
         rsp.ready <= calm || ($urandom_range(0, 99) >= 25);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      timeout_reg = TIMEOUT_RESET;
      hold_reg = HOLD_RESET;
      p_mode = MODE_IDLE; p_prompt = 1; p_comment = 0;
      foreach (p_line[i]) p_line[i] = '0;
      p_wpos = 0; p_ticks = 0;
      csr.valid = 1'b0; csr.index = REG_TIMEOUT; csr.data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // short hold and timeout so the directed part stays brief
      write_reg(REG_TIMEOUT, 16'd30);
      write_reg(REG_HOLD, 16'd2);

      // directed: commands, case folding, comments, null polls, errors
      push_tick(8'hFF);
      push_byte(8'h00); push_byte(8'h7E); push_byte(8'hFF); push_byte(CHAR_CR);
      push_text("LeD oN\r"); push_ticks(2);
      push_text("led off\n"); push_ticks(2);
      push_text("led toggle x y\r"); push_ticks(2);
      push_text("#c/"); push_byte(8'h00); push_byte(8'hFF); push_byte(CHAR_LF);
      push_text("a b c d e\r"); push_ticks(2);
      push_text("led\r"); push_ticks(2);
      push_text("led onn\r"); push_ticks(2);
      wait_drained();

      // line too long, then timeout, at extreme register values
      write_reg(REG_HOLD, 16'd0);
      write_reg(REG_TIMEOUT, 16'd0);
      repeat (LINE_LEN) push_byte(8'h41);
      push_tick(); push_byte(8'h20); push_tick(); push_tick();
      wait_drained();
      write_reg(REG_TIMEOUT, 16'hFFFF);
      write_reg(REG_HOLD, 16'd1);
      push_text("led on"); push_ticks(3); push_byte(CHAR_LF); push_tick();
      wait_drained();

      // random phases at several settings
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(REG_TIMEOUT, ph == 3 ? 16'd1 : 16'($urandom_range(2, 40)));
         write_reg(REG_HOLD, ph == 2 ? 16'd0 : 16'($urandom_range(1, 4)));
         calm = (ph == 1);
         for (int n = 0; n < 275; ) begin
            int before_sz;
            before_sz = pending_beats.size();
            push_random_line();
            n += pending_beats.size() - before_sz;
            while (pending_beats.size() > 16) @(posedge clock);
         end
         wait_drained();
      end

      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule

// File: sim.f
sv/slcp_pkg.sv
sv/slcp_if.sv
sv/slcp_ctrl.sv
sv/slcp_dp.sv
sv/serial_led_command_line_parser_core.sv
tb/tb_slcp_if.sv
tb/tb_serial_led_command_line_parser_core.sv
